// ===== design/tpf_pkg.sv =====
package tpf_pkg;

  localparam int unsigned PKT_LEN     = 38;
  localparam int unsigned PAYLOAD_LEN = 36;
  localparam int unsigned POS_W       = 6;

  localparam logic [POS_W-1:0] POS_CRC_FIRST = 6'd1;
  localparam logic [POS_W-1:0] POS_CRC_LAST  = 6'd35;
  localparam logic [POS_W-1:0] POS_CRC_HI    = 6'd36;
  localparam logic [POS_W-1:0] POS_LAST      = 6'd37;

  localparam logic [7:0]  PKT_START = 8'h23;
  localparam logic [7:0]  PKT_TYPE  = 8'd12;
  localparam logic [7:0]  PKT_LEN_B = 8'd38;
  localparam logic [15:0] CRC_INIT  = 16'hFFFF;
  localparam logic [15:0] CRC_POLY  = 16'hA001;

  localparam int unsigned CFG_DATA_W = 16;

  typedef enum logic [0:0] {
    REG_SERIAL_PREFIX = 1'b0,
    REG_SERIAL_NUMBER = 1'b1
  } cfg_reg_e;

  typedef struct packed {
    logic [31:0] temperature_0;
    logic [31:0] temperature_1;
    logic [31:0] temperature_2;
    logic [31:0] temperature_3;
    logic [15:0] analog_4;
    logic [15:0] analog_5;
    logic [15:0] analog_6;
    logic [15:0] analog_7;
    logic [7:0]  relay_a;
    logic [7:0]  relay_b;
    logic [7:0]  relay_c;
    logic [15:0] pulses;
  } snap_t;

  typedef struct packed {
    logic [7:0] packet_byte;
    logic       last_byte;
  } result_t;

  // one snapshot plus the identity it is sent under
  typedef struct packed {
    snap_t       snap;
    logic [7:0]  dev_prefix;
    logic [15:0] dev_number;
  } frame_t;

  // crc-16/modbus, one byte, lsb first
  function automatic logic [15:0] crc_byte(logic [15:0] crc, logic [7:0] b);
    logic [15:0] c;
    c = crc ^ {8'h00, b};
    for (int k = 0; k < 8; k++) begin
      if (c[0]) begin
        c = (c >> 1) ^ CRC_POLY;
      end else begin
        c = c >> 1;
      end
    end
    return c;
  endfunction

  // payload byte at a packet offset below the crc
  function automatic logic [7:0] frame_byte(frame_t f, logic [POS_W-1:0] pos);
    logic [7:0] b;
    case (pos)
      6'd0:    b = PKT_START;
      6'd1:    b = f.dev_prefix;
      6'd2:    b = f.dev_number[15:8];
      6'd3:    b = f.dev_number[7:0];
      6'd4:    b = PKT_LEN_B;
      6'd5:    b = PKT_TYPE;
      6'd6:    b = f.snap.temperature_0[7:0];
      6'd7:    b = f.snap.temperature_0[15:8];
      6'd8:    b = f.snap.temperature_0[23:16];
      6'd9:    b = f.snap.temperature_0[31:24];
      6'd10:   b = f.snap.temperature_1[7:0];
      6'd11:   b = f.snap.temperature_1[15:8];
      6'd12:   b = f.snap.temperature_1[23:16];
      6'd13:   b = f.snap.temperature_1[31:24];
      6'd14:   b = f.snap.temperature_2[7:0];
      6'd15:   b = f.snap.temperature_2[15:8];
      6'd16:   b = f.snap.temperature_2[23:16];
      6'd17:   b = f.snap.temperature_2[31:24];
      6'd18:   b = f.snap.temperature_3[7:0];
      6'd19:   b = f.snap.temperature_3[15:8];
      6'd20:   b = f.snap.temperature_3[23:16];
      6'd21:   b = f.snap.temperature_3[31:24];
      6'd22:   b = f.snap.analog_4[15:8];
      6'd23:   b = f.snap.analog_4[7:0];
      6'd24:   b = f.snap.analog_5[15:8];
      6'd25:   b = f.snap.analog_5[7:0];
      6'd26:   b = f.snap.analog_6[15:8];
      6'd27:   b = f.snap.analog_6[7:0];
      6'd28:   b = f.snap.analog_7[15:8];
      6'd29:   b = f.snap.analog_7[7:0];
      6'd30:   b = f.snap.relay_a;
      6'd31:   b = f.snap.relay_b;
      6'd32:   b = f.snap.relay_c;
      6'd34:   b = f.snap.pulses[15:8];
      6'd35:   b = f.snap.pulses[7:0];
      default: b = 8'h00; // pad byte
    endcase
    return b;
  endfunction

endpackage

// ===== design/tpf_front.sv =====
module tpf_front #(
  parameter int unsigned QUEUE_DEPTH = 2
) (
  input  logic                             clk_i,
  input  logic                             rst_ni,
  input  logic                             cfg_we_i,
  input  logic [0:0]                       cfg_idx_i,
  input  logic [tpf_pkg::CFG_DATA_W-1:0]   cfg_data_i,
  input  logic                             push,
  output logic                             full,
  input  tpf_pkg::snap_t                   snap_i,
  output logic                             frame_valid_o,
  output tpf_pkg::frame_t                  frame_o,
  input  logic                             frame_pop_i
);

  localparam int unsigned PTR_W = (QUEUE_DEPTH > 1) ? $clog2(QUEUE_DEPTH) : 1;
  localparam int unsigned CNT_W = $clog2(QUEUE_DEPTH + 1);

  logic [7:0]         prefix_q;
  logic [15:0]        serial_q;
  tpf_pkg::frame_t    mem_q [QUEUE_DEPTH];
  logic [PTR_W-1:0]   wr_ptr_q, wr_ptr_d, rd_ptr_q, rd_ptr_d;
  logic [CNT_W-1:0]   cnt_q, cnt_d;
  logic               wr_en, rd_en;
  tpf_pkg::frame_t    wr_frame;

  assign full          = (cnt_q == CNT_W'(QUEUE_DEPTH));
  assign frame_valid_o = (cnt_q != '0);
  assign wr_en         = push && !full;
  assign rd_en         = frame_pop_i && frame_valid_o;
  assign frame_o       = mem_q[rd_ptr_q];

  always_comb begin
    wr_frame.snap       = snap_i;
    wr_frame.dev_prefix = prefix_q;
    wr_frame.dev_number = serial_q;
  end

  always_comb begin
    wr_ptr_d = wr_ptr_q;
    rd_ptr_d = rd_ptr_q;
    cnt_d    = cnt_q;
    if (wr_en) begin
      wr_ptr_d = (wr_ptr_q == PTR_W'(QUEUE_DEPTH - 1)) ? '0 : wr_ptr_q + 1'b1;
    end
    if (rd_en) begin
      rd_ptr_d = (rd_ptr_q == PTR_W'(QUEUE_DEPTH - 1)) ? '0 : rd_ptr_q + 1'b1;
    end
    if (wr_en && !rd_en) begin
      cnt_d = cnt_q + 1'b1;
    end else if (rd_en && !wr_en) begin
      cnt_d = cnt_q - 1'b1;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      prefix_q <= '0;
      serial_q <= '0;
    end else if (cfg_we_i) begin
      case (tpf_pkg::cfg_reg_e'(cfg_idx_i))
        tpf_pkg::REG_SERIAL_PREFIX: prefix_q <= cfg_data_i[7:0];
        tpf_pkg::REG_SERIAL_NUMBER: serial_q <= cfg_data_i[15:0];
        default: ;
      endcase
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      wr_ptr_q <= '0;
      rd_ptr_q <= '0;
      cnt_q    <= '0;
    end else begin
      wr_ptr_q <= wr_ptr_d;
      rd_ptr_q <= rd_ptr_d;
      cnt_q    <= cnt_d;
    end
  end

  always_ff @(posedge clk_i) begin
    if (wr_en) begin
      mem_q[wr_ptr_q] <= wr_frame;
    end
  end

  a_cnt_bound: assert property (@(posedge clk_i) disable iff (!rst_ni)
    cnt_q <= CNT_W'(QUEUE_DEPTH))
    else $error("frame queue count overflow");

  a_full_blocks: assert property (@(posedge clk_i) disable iff (!rst_ni)
    full && !rd_en |=> $stable(wr_ptr_q))
    else $error("frame queue written while full");

  a_cnt_track: assert property (@(posedge clk_i) disable iff (!rst_ni)
    wr_en && !rd_en |=> cnt_q == $past(cnt_q) + 1'b1)
    else $error("frame queue count lost a write");

endmodule

// ===== design/tpf_back.sv =====
module tpf_back (
  input  logic                clk_i,
  input  logic                rst_ni,
  input  logic                frame_valid_i,
  input  tpf_pkg::frame_t     frame_i,
  output logic                frame_pop_o,
  output logic                empty,
  input  logic                pop,
  output tpf_pkg::result_t    result_o
);

  localparam int unsigned OUT_DEPTH = 2;
  localparam int unsigned OCNT_W    = $clog2(OUT_DEPTH + 1);

  logic                          busy_q, busy_d;
  logic [tpf_pkg::POS_W-1:0]     pos_q, pos_d;
  logic [15:0]                   crc_q, crc_d;
  tpf_pkg::frame_t               frame_q;

  tpf_pkg::result_t              out_mem_q [OUT_DEPTH];
  logic                          owr_q, ord_q;
  logic [OCNT_W-1:0]             ocnt_q, ocnt_d;

  logic                          emit, load, last, pop_ok;
  tpf_pkg::result_t              cur;

  assign last   = (pos_q == tpf_pkg::POS_LAST);
  assign emit   = busy_q && (ocnt_q != OCNT_W'(OUT_DEPTH));
  assign load   = frame_valid_i && (!busy_q || (emit && last));
  assign pop_ok = pop && !empty;

  assign frame_pop_o = load;
  assign empty       = (ocnt_q == '0);
  assign result_o    = out_mem_q[ord_q];

  always_comb begin
    if (pos_q < tpf_pkg::POS_W'(tpf_pkg::PAYLOAD_LEN)) begin
      cur.packet_byte = tpf_pkg::frame_byte(frame_q, pos_q);
    end else if (pos_q == tpf_pkg::POS_CRC_HI) begin
      cur.packet_byte = crc_q[15:8];
    end else begin
      cur.packet_byte = crc_q[7:0];
    end
    cur.last_byte = last;
  end

  always_comb begin
    busy_d = busy_q;
    pos_d  = pos_q;
    crc_d  = crc_q;
    if (emit) begin
      pos_d = pos_q + 1'b1;
      if (pos_q inside {[tpf_pkg::POS_CRC_FIRST:tpf_pkg::POS_CRC_LAST]}) begin
        crc_d = tpf_pkg::crc_byte(crc_q, cur.packet_byte);
      end
      if (last) begin
        busy_d = 1'b0;
      end
    end
    if (load) begin
      busy_d = 1'b1;
      pos_d  = '0;
      crc_d  = tpf_pkg::CRC_INIT;
    end
  end

  always_comb begin
    ocnt_d = ocnt_q;
    if (emit && !pop_ok) begin
      ocnt_d = ocnt_q + 1'b1;
    end else if (pop_ok && !emit) begin
      ocnt_d = ocnt_q - 1'b1;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      busy_q <= 1'b0;
      pos_q  <= '0;
      crc_q  <= tpf_pkg::CRC_INIT;
      owr_q  <= 1'b0;
      ord_q  <= 1'b0;
      ocnt_q <= '0;
    end else begin
      busy_q <= busy_d;
      pos_q  <= pos_d;
      crc_q  <= crc_d;
      ocnt_q <= ocnt_d;
      if (emit) begin
        owr_q <= ~owr_q;
      end
      if (pop_ok) begin
        ord_q <= ~ord_q;
      end
    end
  end

  always_ff @(posedge clk_i) begin
    if (load) begin
      frame_q <= frame_i;
    end
    if (emit) begin
      out_mem_q[owr_q] <= cur;
    end
  end

  a_ocnt_bound: assert property (@(posedge clk_i) disable iff (!rst_ni)
    ocnt_q <= OCNT_W'(OUT_DEPTH))
    else $error("result buffer overflow");

  a_pos_range: assert property (@(posedge clk_i) disable iff (!rst_ni)
    busy_q |-> pos_q <= tpf_pkg::POS_LAST)
    else $error("byte position past packet end");

  a_start_mark: assert property (@(posedge clk_i) disable iff (!rst_ni)
    emit && pos_q == '0 |-> cur.packet_byte == tpf_pkg::PKT_START && !cur.last_byte)
    else $error("packet does not open with start mark");

  a_load_gap: assert property (@(posedge clk_i) disable iff (!rst_ni)
    busy_q && !(emit && last) |-> !load)
    else $error("new frame loaded mid packet");

endmodule

// ===== design/telemetry_packet_framer_crc16.sv =====
// telemetry packet framer with crc-16/modbus
//
// input channel: a snapshot word on snap_i is taken when push is high and
// full is low. the front holds up to QUEUE_DEPTH snapshots, stamped with the
// serial prefix and serial number current when they were taken.
// output channel: each snapshot becomes a 38-word packet, one byte per word,
// last_byte set on the final crc byte. the oldest word sits on result_o while
// empty is low and leaves when pop is high.
// config: cfg_we_i writes cfg_data_i into register cfg_idx_i (0 serial
// prefix, 1 serial number); write only while no packet is in flight.
// latency: a snapshot is written into the front queue, then loaded into the
// serializer's frame register, and its first byte goes into the result buffer.
// throughput: one byte per cycle while the result buffer has room, set by the
// serializer that emits a byte and folds it into the crc in the same cycle;
// the next packet follows its predecessor's last byte directly.
// stall: when pop is held low the two-entry result buffer fills and the
// serializer waits; snapshots still queue in the front until full rises.
// reset: queues empty, config registers zero, crc back to 0xffff.
module telemetry_packet_framer_crc16 #(
  parameter int unsigned QUEUE_DEPTH = 2
) (
  input  logic                           clk_i,
  input  logic                           rst_ni,
  input  logic                           cfg_we_i,
  input  logic [0:0]                     cfg_idx_i,
  input  logic [tpf_pkg::CFG_DATA_W-1:0] cfg_data_i,
  input  logic                           push,
  output logic                           full,
  input  tpf_pkg::snap_t                 snap_i,
  output logic                           empty,
  input  logic                           pop,
  output tpf_pkg::result_t               result_o
);

  logic            frame_valid;
  logic            frame_pop;
  tpf_pkg::frame_t frame;

  tpf_front #(
    .QUEUE_DEPTH (QUEUE_DEPTH)
  ) u_front (
    .clk_i         (clk_i),
    .rst_ni        (rst_ni),
    .cfg_we_i      (cfg_we_i),
    .cfg_idx_i     (cfg_idx_i),
    .cfg_data_i    (cfg_data_i),
    .push          (push),
    .full          (full),
    .snap_i        (snap_i),
    .frame_valid_o (frame_valid),
    .frame_o       (frame),
    .frame_pop_i   (frame_pop)
  );

  tpf_back u_back (
    .clk_i         (clk_i),
    .rst_ni        (rst_ni),
    .frame_valid_i (frame_valid),
    .frame_i       (frame),
    .frame_pop_o   (frame_pop),
    .empty         (empty),
    .pop           (pop),
    .result_o      (result_o)
  );

endmodule

// ===== sim/telemetry_packet_framer_crc16_tb.sv =====
module telemetry_packet_framer_crc16_tb;
  timeunit 1ns;
  timeprecision 1ps;

  typedef logic [7:0] pkt_bytes_t [tpf_pkg::PKT_LEN];

  // how the body bytes (offsets 6..35 but the pad) of a directed row are known
  typedef enum {BODY_PREDICTED, BODY_FLAT, BODY_OFFSET} body_kind_e;

  typedef struct {
    tpf_pkg::snap_t snap;
    body_kind_e     kind;
    logic [7:0]     fill;
  } snap_row_t;

  logic                           clk_i = 1'b0;
  logic                           rst_ni;
  logic                           cfg_we_i;
  logic [0:0]                     cfg_idx_i;
  logic [tpf_pkg::CFG_DATA_W-1:0] cfg_data_i;
  logic                           push;
  logic                           full;
  tpf_pkg::snap_t                 snap_i;
  logic                           empty;
  logic                           pop = 1'b0;
  tpf_pkg::result_t               result_o;

  tpf_pkg::result_t packet_bytes_q [$];
  snap_row_t        dir_rows [$];
  logic [7:0]       id_prefix = 8'h00;
  logic [15:0]      id_serial = 16'h0000;
  bit               steady    = 1'b0;
  int               err_cnt   = 0;

  telemetry_packet_framer_crc16 dut (
    .clk_i      (clk_i),
    .rst_ni     (rst_ni),
    .cfg_we_i   (cfg_we_i),
    .cfg_idx_i  (cfg_idx_i),
    .cfg_data_i (cfg_data_i),
    .push       (push),
    .full       (full),
    .snap_i     (snap_i),
    .empty      (empty),
    .pop        (pop),
    .result_o   (result_o)
  );

  always begin
    #6 clk_i = 1'b1;
    #6 clk_i = 1'b0;
  end

  function automatic logic [15:0] modbus_crc_step(logic [15:0] crc, logic [7:0] b);
    logic [15:0] r;
    r = crc ^ {8'h00, b};
    repeat (8) begin
      if (r[0]) begin
        r = (r >> 1) ^ 16'hA001;
      end else begin
        r = r >> 1;
      end
    end
    return r;
  endfunction

  // whole packet for one snapshot under the current identity
  function automatic void frame_snapshot(input tpf_pkg::snap_t s, output pkt_bytes_t pkt);
    logic [31:0] temps [4];
    logic [15:0] analogs [4];
    logic [15:0] crc;
    temps   = '{s.temperature_0, s.temperature_1, s.temperature_2, s.temperature_3};
    analogs = '{s.analog_4, s.analog_5, s.analog_6, s.analog_7};
    pkt[0] = 8'h23;
    pkt[1] = id_prefix;
    pkt[2] = id_serial[15:8];
    pkt[3] = id_serial[7:0];
    pkt[4] = 8'd38;
    pkt[5] = 8'd12;
    for (int ch = 0; ch < 4; ch++) begin
      for (int i = 0; i < 4; i++) begin
        pkt[6 + ch * 4 + i] = temps[ch][8 * i +: 8];
      end
      pkt[22 + ch * 2] = analogs[ch][15:8];
      pkt[23 + ch * 2] = analogs[ch][7:0];
    end
    pkt[30] = s.relay_a;
    pkt[31] = s.relay_b;
    pkt[32] = s.relay_c;
    pkt[33] = 8'h00;
    pkt[34] = s.pulses[15:8];
    pkt[35] = s.pulses[7:0];
    crc = 16'hFFFF;
    for (int i = 1; i <= 35; i++) begin
      crc = modbus_crc_step(crc, pkt[i]);
    end
    pkt[36] = crc[15:8];
    pkt[37] = crc[7:0];
  endfunction

  function automatic logic [31:0] pick_bits(int unsigned w);
    logic [31:0] mask;
    mask = (w >= 32) ? 32'hFFFF_FFFF : ((32'd1 << w) - 32'd1);
    case ($urandom_range(7))
      0: return 32'h0;
      1: return mask;
      default: return $urandom & mask;
    endcase
  endfunction

  function automatic tpf_pkg::snap_t random_snapshot();
    tpf_pkg::snap_t s;
    s.temperature_0 = pick_bits(32);
    s.temperature_1 = pick_bits(32);
    s.temperature_2 = pick_bits(32);
    s.temperature_3 = pick_bits(32);
    s.analog_4      = 16'(pick_bits(16));
    s.analog_5      = 16'(pick_bits(16));
    s.analog_6      = 16'(pick_bits(16));
    s.analog_7      = 16'(pick_bits(16));
    s.relay_a       = 8'(pick_bits(8));
    s.relay_b       = 8'(pick_bits(8));
    s.relay_c       = 8'(pick_bits(8));
    s.pulses        = 16'(pick_bits(16));
    return s;
  endfunction

  function automatic tpf_pkg::snap_t flat_snap(logic [7:0] fill);
    return '{{4{fill}}, {4{fill}}, {4{fill}}, {4{fill}},
             {2{fill}}, {2{fill}}, {2{fill}}, {2{fill}},
             fill, fill, fill, {2{fill}}};
  endfunction

  task automatic send_snap(tpf_pkg::snap_t s, body_kind_e kind, logic [7:0] fill);
    pkt_bytes_t pkt;
    if (!steady && $urandom_range(99) < 38) begin
      push <= 1'b0;
      do @(posedge clk_i); while ($urandom_range(99) < 38);
    end
    push   <= 1'b1;
    snap_i <= s;
    do @(posedge clk_i); while (full);
    frame_snapshot(s, pkt);
    for (int i = 6; i < 36; i++) begin
      if (i != 33) begin
        case (kind)
          BODY_FLAT:   pkt[i] = fill;
          BODY_OFFSET: pkt[i] = 8'(i);
          default: ;
        endcase
      end
    end
    for (int i = 0; i < tpf_pkg::PKT_LEN; i++) begin
      packet_bytes_q.push_back('{pkt[i], i == tpf_pkg::PKT_LEN - 1});
    end
  endtask

  task automatic drain_packets();
    push <= 1'b0;
    while (packet_bytes_q.size() != 0) @(posedge clk_i);
    repeat (8) @(posedge clk_i);
  endtask

  // upper data bits of the prefix write carry junk, the register keeps 8 bits
  task automatic write_ids(logic [7:0] prefix, logic [15:0] serial);
    cfg_we_i   <= 1'b1;
    cfg_idx_i  <= tpf_pkg::REG_SERIAL_PREFIX;
    cfg_data_i <= {8'($urandom), prefix};
    @(posedge clk_i);
    cfg_idx_i  <= tpf_pkg::REG_SERIAL_NUMBER;
    cfg_data_i <= serial;
    @(posedge clk_i);
    cfg_we_i   <= 1'b0;
    id_prefix = prefix;
    id_serial = serial;
  endtask

  // result side: check the word taken at this edge, then pick the next pop
  always @(posedge clk_i) begin : sink
    tpf_pkg::result_t want;
    if (rst_ni && pop && !empty) begin
      if (packet_bytes_q.size() == 0) begin
        $error("unexpected word: packet_byte %02h last_byte %0b",
               result_o.packet_byte, result_o.last_byte);
        err_cnt++;
      end else begin
        want = packet_bytes_q.pop_front();
        if (result_o.packet_byte !== want.packet_byte) begin
          $error("packet_byte: expected %02h, got %02h",
                 want.packet_byte, result_o.packet_byte);
          err_cnt++;
        end
        if (result_o.last_byte !== want.last_byte) begin
          $error("last_byte: expected %0b, got %0b", want.last_byte, result_o.last_byte);
          err_cnt++;
        end
      end
    end
    pop <= rst_ni && (steady || $urandom_range(99) >= 38);
  end

  initial begin
    #5_000_000;
    $display("DONE: errors detected");
    $finish;
  end

  initial begin
    tpf_pkg::snap_t s;
    push       <= 1'b0;
    snap_i     <= '0;
    cfg_we_i   <= 1'b0;
    cfg_idx_i  <= tpf_pkg::REG_SERIAL_PREFIX;
    cfg_data_i <= '0;
    rst_ni     <= 1'b0;

    dir_rows.push_back('{flat_snap(8'h00), BODY_FLAT, 8'h00});
    dir_rows.push_back('{flat_snap(8'hFF), BODY_FLAT, 8'hFF});
    dir_rows.push_back('{flat_snap(8'h55), BODY_FLAT, 8'h55});
    dir_rows.push_back('{flat_snap(8'hAA), BODY_FLAT, 8'hAA});
    dir_rows.push_back('{flat_snap(8'h80), BODY_FLAT, 8'h80});
    dir_rows.push_back('{flat_snap(8'h01), BODY_FLAT, 8'h01});
    // each body byte equals its packet offset, catches byte order slips
    dir_rows.push_back('{'{32'h0908_0706, 32'h0D0C_0B0A, 32'h1110_0F0E, 32'h1514_1312,
                           16'h1617, 16'h1819, 16'h1A1B, 16'h1C1D,
                           8'h1E, 8'h1F, 8'h20, 16'h2223}, BODY_OFFSET, 8'h00});
    s = flat_snap(8'h00);
    s.temperature_0 = '1; s.temperature_1 = '1; s.temperature_2 = '1; s.temperature_3 = '1;
    dir_rows.push_back('{s, BODY_PREDICTED, 8'h00});
    s = flat_snap(8'h00);
    s.analog_4 = '1; s.analog_5 = '1; s.analog_6 = '1; s.analog_7 = '1;
    dir_rows.push_back('{s, BODY_PREDICTED, 8'h00});
    s = flat_snap(8'h00);
    s.relay_a = '1; s.relay_b = '1; s.relay_c = '1;
    dir_rows.push_back('{s, BODY_PREDICTED, 8'h00});
    s = flat_snap(8'h00);
    s.pulses = '1;
    dir_rows.push_back('{s, BODY_PREDICTED, 8'h00});
    dir_rows.push_back('{random_snapshot(), BODY_PREDICTED, 8'h00});
    dir_rows.push_back('{random_snapshot(), BODY_PREDICTED, 8'h00});

    repeat (8) @(posedge clk_i);
    rst_ni <= 1'b1;
    @(posedge clk_i);

    // directed rows run under the reset identity
    foreach (dir_rows[r]) begin
      send_snap(dir_rows[r].snap, dir_rows[r].kind, dir_rows[r].fill);
    end

    for (int ph = 0; ph < 6; ph++) begin
      drain_packets();
      case (ph)
        0: write_ids(8'hFF, 16'hFFFF);
        1: write_ids(8'h00, 16'h0000);
        2: write_ids(8'h5A, 16'hA5C3);
        default: write_ids(8'($urandom), 16'($urandom));
      endcase
      // one phase with neither side idling
      steady = (ph == 2);
      for (int n = 0; n < 68; n++) begin
        send_snap(random_snapshot(), BODY_PREDICTED, 8'h00);
      end
    end
    steady = 1'b0;
    drain_packets();
    repeat (40) @(posedge clk_i);

    if (err_cnt == 0) begin
      $display("DONE: 0 errors");
    end else begin
      $display("DONE: errors detected");
    end
    $finish;
  end

endmodule
